>>> sv/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg: SuperFastHash stream package
// Field widths, length mask and the mixing functions of the hash.
// ----------------------------------------------------------------------------
package shs_pkg;

  // Item field widths
  localparam int WORD_W   = 32;
  localparam int NBYTES_W = 3;
  localparam int MLEN_W   = 16;
  localparam int HASH_W   = 31;

  // Low bits of the length field that seed the hash (1 to 32)
  localparam int LENGTH_BITS = 16;
  localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  // Valid byte counts of a last item
  localparam logic [NBYTES_W-1:0] NB_NONE  = 3'd0;
  localparam logic [NBYTES_W-1:0] NB_ONE   = 3'd1;
  localparam logic [NBYTES_W-1:0] NB_TWO   = 3'd2;
  localparam logic [NBYTES_W-1:0] NB_THREE = 3'd3;

  // Byte sign extension, as the C code does on char
  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  // One round over a full 32-bit chunk
  function automatic logic [31:0] full_round(input logic [31:0] h,
                                             input logic [31:0] w);
    logic [31:0] h1;
    logic [31:0] t;
    logic [31:0] h2;
    h1 = h + {16'd0, w[15:0]};
    t  = {5'd0, w[31:16], 11'd0} ^ h1;
    h2 = {h1[15:0], 16'd0} ^ t;
    return h2 + (h2 >> 11);
  endfunction

  // Mixing of a last item: full round, a tail of 1 to 3 bytes, or no change for no bytes
  function automatic logic [31:0] last_mix(input logic [31:0] h,
                                           input logic [31:0] w,
                                           input logic [NBYTES_W-1:0] nb);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    a = '0;
    b = '0;
    r = h;
    unique case (nb)
      NB_NONE: begin
        r = h;
      end
      NB_ONE: begin
        a = h + sext8(w[7:0]);
        b = a ^ (a << 10);
        r = b + (b >> 1);
      end
      NB_TWO: begin
        a = h + {16'd0, w[15:0]};
        b = a ^ (a << 11);
        r = b + (b >> 17);
      end
      NB_THREE: begin
        a = h + {16'd0, w[15:0]};
        a = a ^ (a << 16);
        b = a ^ (sext8(w[23:16]) << 18);
        r = b + (b >> 11);
      end
      // four or more bytes: a full round
      default: begin
        r = full_round(h, w);
      end
    endcase
    return r;
  endfunction

  // First half of the avalanche
  function automatic logic [31:0] avalanche_a(input logic [31:0] h);
    logic [31:0] a;
    logic [31:0] b;
    a = h ^ (h << 3);
    b = a + (a >> 5);
    return b ^ (b << 4);
  endfunction

  // Second half of the avalanche
  function automatic logic [31:0] avalanche_b(input logic [31:0] h);
    logic [31:0] a;
    logic [31:0] b;
    a = h + (h >> 17);
    b = a ^ (a << 25);
    return b + (b >> 6);
  endfunction

endpackage

>>> sv/shs_if.sv
// ----------------------------------------------------------------------------
// shs_if: SuperFastHash stream channels
// Valid/ready channels for message chunks and for finished hashes.
// ----------------------------------------------------------------------------

// Message chunk channel
interface shs_in_if;
  logic                          valid;
  logic                          ready;
  logic [shs_pkg::WORD_W-1:0]    data_word;
  logic [shs_pkg::NBYTES_W-1:0]  valid_bytes;
  logic                          last;
  logic [shs_pkg::MLEN_W-1:0]    message_length;

  modport source (output valid, output data_word, output valid_bytes,
                  output last, output message_length, input ready);
  modport sink   (input valid, input data_word, input valid_bytes,
                  input last, input message_length, output ready);
endinterface

// Hash result channel
interface shs_out_if;
  logic                        valid;
  logic                        ready;
  logic [shs_pkg::HASH_W-1:0]  hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

>>> sv/superfast_hash_stream.sv
// ----------------------------------------------------------------------------
// superfast_hash_stream: streaming 31-bit SuperFastHash
// Hashes a byte message fed as 32-bit chunks and emits one hash per message.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries message chunks, first byte in data_word[7:0]. The first
//   item of a message seeds the hash with message_length; every non-last
//   item must hold four bytes. The item with last set holds 0 to 4 bytes
//   and closes the message. A zero-length message is one last item with
//   length 0 and no bytes.
//   out_chan carries one hash_value per message.
// Timing:
//   One item per cycle unless in_chan.ready is low. The running hash
//   is updated in the cycle of accept; the tail mix and two avalanche
//   halves pass through a three-register pipeline (stage 1, stage 2,
//   output register) before the hash is valid on out_chan.
// Reset:
//   rst empties the pipeline and arms the block for a new message.
// Backpressure:
//   While out_chan stalls, the pipeline fills and then in_chan.ready drops;
//   no hash is lost or repeated.
// ----------------------------------------------------------------------------
module superfast_hash_stream (
  input  logic       clk,
  input  logic       rst,
  shs_in_if.sink     in_chan,
  shs_out_if.source  out_chan
);

  // Message state
  logic        awaiting_first;
  logic [31:0] running_hash;

  // Pipeline registers
  logic        s1_valid;
  logic [31:0] s1_hash;
  logic        s2_valid;
  logic [31:0] s2_hash;
  logic        out_valid;
  logic [shs_pkg::HASH_W-1:0] out_hash;

  // Stage handshakes
  logic out_free;
  logic s2_free;
  logic s1_free;
  logic accept;

  // Hash seen by the incoming item
  logic [31:0] cur_hash;
  logic [31:0] seed;
  logic [31:0] fin_hash;

  assign out_free = !out_valid || out_chan.ready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign accept   = in_chan.valid && s1_free;

  assign in_chan.ready       = s1_free;
  assign out_chan.valid      = out_valid;
  assign out_chan.hash_value = out_hash;

  // Seed from the length field on a message's first item
  assign seed     = {16'd0, in_chan.message_length} & shs_pkg::LEN_MASK;
  assign cur_hash = awaiting_first ? seed : running_hash;
  assign fin_hash = shs_pkg::avalanche_b(s2_hash);

  // Running hash and message framing
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_first <= 1'b1;
      running_hash   <= '0;
    end else if (accept) begin
      if (in_chan.last) begin
        awaiting_first <= 1'b1;
        running_hash   <= '0;
      end else begin
        awaiting_first <= 1'b0;
        running_hash   <= shs_pkg::full_round(cur_hash, in_chan.data_word);
      end
    end
  end

  // Stage 1: tail mix of the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept && in_chan.last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_chan.last) begin
      s1_hash <= shs_pkg::last_mix(cur_hash, in_chan.data_word, in_chan.valid_bytes);
    end
  end

  // Stage 2: first avalanche half
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_hash <= shs_pkg::avalanche_a(s1_hash);
    end
  end

  // Output register: second avalanche half, masked to 31 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      out_hash <= fin_hash[shs_pkg::HASH_W-1:0];
    end
  end

endmodule
